// ===== hdl/fcp_pkg.sv =====
// Shared types, codes and saturation helpers for the frustum culling plane block.
package fcp_pkg;

   localparam int NUM_CFG = 6;

   localparam logic [2:0] CFG_LEFT   = 3'd0;
   localparam logic [2:0] CFG_RIGHT  = 3'd1;
   localparam logic [2:0] CFG_BOTTOM = 3'd2;
   localparam logic [2:0] CFG_TOP    = 3'd3;
   localparam logic [2:0] CFG_NEAR   = 3'd4;
   localparam logic [2:0] CFG_FAR    = 3'd5;

   localparam logic [2:0] PLANE_LEFT   = 3'd0;
   localparam logic [2:0] PLANE_RIGHT  = 3'd1;
   localparam logic [2:0] PLANE_BOTTOM = 3'd2;
   localparam logic [2:0] PLANE_TOP    = 3'd3;
   localparam logic [2:0] PLANE_NEAR   = 3'd4;
   localparam logic [2:0] PLANE_FAR    = 3'd5;

   typedef logic [5:0][31:0] cfg_type;

   typedef struct packed {
      logic [2:0][47:0] pos;
      logic [2:0][31:0] dir;
      logic [2:0][31:0] up;
      logic [2:0][31:0] rt;
   } pose_type;

   typedef struct packed {
      logic [2:0]       plane_index;
      logic [2:0][31:0] normal;
      logic [47:0]      plane_offset;
      logic             degenerate;
      logic             last_plane;
   } plane_type;

   function automatic logic [31:0] sat32(input logic signed [36:0] v);
      logic [31:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -37'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] sat48(input logic signed [52:0] v);
      logic [47:0] r;
      if (v > 53'sh7FFF_FFFF_FFFF) begin
         r = 48'h7FFF_FFFF_FFFF;
      end else if (v < -53'sh8000_0000_0000) begin
         r = 48'h8000_0000_0000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/fcp_queue.sv =====
// Small flop-based FIFO used between the stages and on the result side.
module fcp_queue
   import fcp_pkg::*;
#(
   parameter type item_type = logic,
   parameter int Depth = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_item,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_item,
   output logic     empty
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam logic [AW-1:0] LAST = AW'(Depth - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(Depth);

   item_type      mem_ff [Depth];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full    = (count_ff == DEPTH_C);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ===== hdl/fcp_front.sv =====
// Front stage: takes a camera pose and forms the right axis dir x up.
module fcp_front
   import fcp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [2:0][47:0] pos,
   input  logic [2:0][31:0] dir,
   input  logic [2:0][31:0] up,
   output logic             q_push,
   output pose_type         q_item,
   input  logic             q_full
);
   localparam int DA [6] = '{1, 2, 2, 0, 0, 1};
   localparam int UB [6] = '{2, 1, 0, 2, 1, 0};

   logic                    valid_ff, valid_in;
   logic [2:0][47:0]        pos_ff;
   logic [2:0][31:0]        dir_ff;
   logic [2:0][31:0]        up_ff;
   logic signed [63:0]      prod_ff [6];
   logic                    accept;
   logic signed [36:0]      diff [3];

   assign full   = valid_ff & q_full;
   assign accept = push & ~full;
   assign q_push = valid_ff;
   assign valid_in = accept | (valid_ff & q_full);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = {{3{prod_ff[2*c][63]}}, prod_ff[2*c][63:30]}
                 - {{3{prod_ff[2*c+1][63]}}, prod_ff[2*c+1][63:30]};
      end
      q_item.pos = pos_ff;
      q_item.dir = dir_ff;
      q_item.up  = up_ff;
      for (int c = 0; c < 3; c++) begin
         q_item.rt[c] = sat32(diff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= pos;
         dir_ff <= dir;
         up_ff  <= up;
         for (int j = 0; j < 6; j++) begin
            prod_ff[j] <= $signed(dir[DA[j]]) * $signed(up[UB[j]]);
         end
      end
   end

endmodule

// ===== hdl/fcp_engine.sv =====
// Back stage: sequencer that builds the six planes with one shared multiplier.
module fcp_engine
   import fcp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_empty,
   input  pose_type  q_item,
   output logic      q_pop,
   output logic      o_push,
   output plane_type o_item,
   input  logic      o_full
);
   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_EDGE   = 11'b000_0000_0010,
      S_MAG    = 11'b000_0000_0100,
      S_NORM   = 11'b000_0000_1000,
      S_SQ     = 11'b000_0001_0000,
      S_SQRT   = 11'b000_0010_0000,
      S_DIV    = 11'b000_0100_0000,
      S_CROSS  = 11'b000_1000_0000,
      S_POINT  = 11'b001_0000_0000,
      S_OFFSET = 11'b010_0000_0000,
      S_EMIT   = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic [2:0]         k_ff, k_in;
   pose_type           pose_ff, pose_in;
   logic signed [49:0] e_ff [3];
   logic signed [49:0] e_in [3];
   logic [48:0]        mag_ff, mag_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        r_ff, r_in;
   logic [32:0]        rem_ff [3];
   logic [32:0]        rem_in [3];
   logic [30:0]        quo_ff [3];
   logic [30:0]        quo_in [3];
   logic [31:0]        len_ff, len_in;
   logic [31:0]        u_ff [3];
   logic [31:0]        u_in [3];
   logic [31:0]        n_ff [3];
   logic [31:0]        n_in [3];
   logic [47:0]        pt_ff [3];
   logic [47:0]        pt_in [3];
   logic signed [81:0] acc_ff, acc_in;
   logic signed [35:0] tmp_ff, tmp_in;
   logic               deg_ff, deg_in;
   logic signed [65:0] prod_ff;

   logic signed [32:0] mul_a, mul_b;
   logic [2:0]         idx, cj;
   logic [1:0]         isel, csel, ic, cc;
   logic [31:0]        ax [3];
   logic [31:0]        ca [3];
   logic [31:0]        cb [3];
   logic [31:0]        tabs [3];
   logic [31:0]        absv;
   logic [63:0]        bval, rb;
   logic [32:0]        rshift;
   logic [52:0]        neg_off;

   function automatic logic [1:0] cross_a(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0: r = 2'd1;
         3'd1: r = 2'd2;
         3'd2: r = 2'd2;
         3'd3: r = 2'd0;
         3'd4: r = 2'd0;
         3'd5: r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_b(input logic [2:0] j);
      logic [1:0] r;
      case (j)
         3'd0: r = 2'd2;
         3'd1: r = 2'd1;
         3'd2: r = 2'd0;
         3'd3: r = 2'd2;
         3'd4: r = 2'd1;
         3'd5: r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [48:0] abs50(input logic signed [49:0] v);
      logic [49:0] r;
      r = v[49] ? 50'(-v) : 50'(v);
      return r[48:0];
   endfunction

   assign idx  = step_ff[2:0];
   assign cj   = idx - 3'd1;
   assign isel = (idx > 3'd2) ? 2'd0 : idx[1:0];
   assign csel = (cj > 3'd2) ? 2'd0 : cj[1:0];
   assign ic   = (idx > 3'd5) ? 2'd0 : idx[2:1];
   assign cc   = (cj > 3'd5) ? 2'd0 : cj[2:1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[i]   = k_ff[1] ? pose_ff.up[i] : pose_ff.rt[i];
         tabs[i] = e_ff[i][31] ? 32'(-e_ff[i][31:0]) : e_ff[i][31:0];
         case (k_ff)
            PLANE_LEFT: begin
               ca[i] = u_ff[i];
               cb[i] = pose_ff.up[i];
            end
            PLANE_RIGHT: begin
               ca[i] = pose_ff.up[i];
               cb[i] = u_ff[i];
            end
            PLANE_BOTTOM: begin
               ca[i] = pose_ff.rt[i];
               cb[i] = u_ff[i];
            end
            default: begin
               ca[i] = u_ff[i];
               cb[i] = pose_ff.rt[i];
            end
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_EDGE: begin
            if (!idx[0]) begin
               mul_a = $signed({ax[ic][31], ax[ic]});
               mul_b = $signed({cfg[k_ff[1:0]][31], cfg[k_ff[1:0]]});
            end else begin
               mul_a = $signed({pose_ff.dir[ic][31], pose_ff.dir[ic]});
               mul_b = $signed({cfg[CFG_NEAR][31], cfg[CFG_NEAR]});
            end
         end
         S_SQ: begin
            mul_a = $signed({e_ff[isel][31], e_ff[isel][31:0]});
            mul_b = $signed({e_ff[isel][31], e_ff[isel][31:0]});
         end
         S_CROSS: begin
            mul_a = $signed({ca[cross_a(idx)][31], ca[cross_a(idx)]});
            mul_b = $signed({cb[cross_b(idx)][31], cb[cross_b(idx)]});
         end
         S_POINT: begin
            mul_a = $signed({pose_ff.dir[isel][31], pose_ff.dir[isel]});
            if (k_ff == PLANE_NEAR) begin
               mul_b = $signed({cfg[CFG_NEAR][31], cfg[CFG_NEAR]});
            end else begin
               mul_b = $signed({cfg[CFG_FAR][31], cfg[CFG_FAR]});
            end
         end
         S_OFFSET: begin
            mul_a = $signed({n_ff[ic][31], n_ff[ic]});
            if (!idx[0]) begin
               mul_b = $signed({pt_ff[ic][47], pt_ff[ic][47:16]});
            end else begin
               mul_b = $signed({17'd0, pt_ff[ic][15:0]});
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign bval    = 64'd1 << {step_ff, 1'b0};
   assign rb      = r_ff + bval;
   assign neg_off = 53'(-$signed({acc_ff[81], acc_ff[81:30]}));

   always_comb begin
      o_item.plane_index  = k_ff;
      o_item.normal[0]    = n_ff[0];
      o_item.normal[1]    = n_ff[1];
      o_item.normal[2]    = n_ff[2];
      o_item.plane_offset = sat48(neg_off);
      o_item.degenerate   = deg_ff;
      o_item.last_plane   = (k_ff == PLANE_FAR);
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      k_in     = k_ff;
      pose_in  = pose_ff;
      e_in     = e_ff;
      mag_in   = mag_ff;
      sum_in   = sum_ff;
      v_in     = v_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      len_in   = len_ff;
      u_in     = u_ff;
      n_in     = n_ff;
      pt_in    = pt_ff;
      acc_in   = acc_ff;
      tmp_in   = tmp_ff;
      deg_in   = deg_ff;
      q_pop    = 1'b0;
      o_push   = 1'b0;
      absv     = '0;
      rshift   = '0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               pose_in  = q_item;
               k_in     = PLANE_LEFT;
               step_in  = '0;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (step_ff != 5'd0) begin
               if (!cj[0]) begin
                  e_in[cc] = prod_ff[65:16];
               end else begin
                  e_in[cc] = e_ff[cc] + prod_ff[65:16];
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd6) begin
               step_in  = '0;
               state_in = S_MAG;
            end
         end
         S_MAG: begin
            mag_in = abs50(e_ff[0]);
            if (abs50(e_ff[1]) > mag_in) mag_in = abs50(e_ff[1]);
            if (abs50(e_ff[2]) > mag_in) mag_in = abs50(e_ff[2]);
            deg_in = (mag_in == '0);
            if (mag_in == '0) begin
               for (int i = 0; i < 3; i++) n_in[i] = '0;
               acc_in   = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (mag_ff[48:31] != '0) begin
               mag_in = mag_ff >> 1;
               for (int i = 0; i < 3; i++) e_in[i] = e_ff[i] >>> 1;
            end else if (!mag_ff[30]) begin
               mag_in = mag_ff << 1;
               for (int i = 0; i < 3; i++) e_in[i] = e_ff[i] <<< 1;
            end else begin
               sum_in   = '0;
               step_in  = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (step_ff != 5'd0) begin
               sum_in = sum_ff + prod_ff[63:0];
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               v_in     = sum_in;
               r_in     = '0;
               step_in  = 5'd31;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (v_ff >= rb) begin
               v_in = v_ff - rb;
               r_in = (r_ff >> 1) + bval;
            end else begin
               r_in = r_ff >> 1;
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               len_in = r_in[31:0];
               for (int i = 0; i < 3; i++) begin
                  rem_in[i] = {2'b00, tabs[i][31:1]};
                  quo_in[i] = '0;
               end
               step_in  = 5'd30;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               rshift = {rem_ff[i][31:0], (step_ff == 5'd30) ? tabs[i][0] : 1'b0};
               if (rshift >= {1'b0, len_ff}) begin
                  rem_in[i] = rshift - {1'b0, len_ff};
                  quo_in[i] = {quo_ff[i][29:0], 1'b1};
               end else begin
                  rem_in[i] = rshift;
                  quo_in[i] = {quo_ff[i][29:0], 1'b0};
               end
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               for (int i = 0; i < 3; i++) begin
                  absv    = {1'b0, quo_in[i]};
                  u_in[i] = e_ff[i][31] ? 32'(-absv) : absv;
               end
               step_in  = '0;
               state_in = S_CROSS;
            end
         end
         S_CROSS: begin
            if (step_ff != 5'd0) begin
               if (!cj[0]) begin
                  tmp_in = prod_ff[65:30];
               end else begin
                  n_in[cc] = sat32({tmp_ff[35], tmp_ff}
                                 - {prod_ff[65], prod_ff[65:30]});
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd6) begin
               for (int i = 0; i < 3; i++) pt_in[i] = pose_ff.pos[i];
               acc_in   = '0;
               step_in  = '0;
               state_in = S_OFFSET;
            end
         end
         S_POINT: begin
            if (step_ff != 5'd0) begin
               pt_in[csel] = sat48(53'($signed({{5{pose_ff.pos[csel][47]}},
                                                pose_ff.pos[csel]}))
                                 + 53'($signed(prod_ff[65:30])));
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               for (int i = 0; i < 3; i++) begin
                  if (k_ff == PLANE_NEAR) begin
                     n_in[i] = pose_ff.dir[i];
                  end else begin
                     n_in[i] = sat32(-$signed({{5{pose_ff.dir[i][31]}}, pose_ff.dir[i]}));
                  end
               end
               deg_in   = 1'b0;
               acc_in   = '0;
               step_in  = '0;
               state_in = S_OFFSET;
            end
         end
         S_OFFSET: begin
            if (step_ff != 5'd0) begin
               if (!cj[0]) begin
                  acc_in = acc_ff + ($signed({{16{prod_ff[65]}}, prod_ff}) <<< 16);
               end else begin
                  acc_in = acc_ff + $signed({{16{prod_ff[65]}}, prod_ff});
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd6) begin
               step_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!o_full) begin
               o_push  = 1'b1;
               step_in = '0;
               if (k_ff == PLANE_FAR) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 3'd1;
                  if ((k_ff == PLANE_TOP) || (k_ff == PLANE_NEAR)) begin
                     state_in = S_POINT;
                  end else begin
                     state_in = S_EDGE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      pose_ff <= pose_in;
      e_ff    <= e_in;
      mag_ff  <= mag_in;
      sum_ff  <= sum_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      len_ff  <= len_in;
      u_ff    <= u_in;
      n_ff    <= n_in;
      pt_ff   <= pt_in;
      acc_ff  <= acc_in;
      tmp_ff  <= tmp_in;
      deg_ff  <= deg_in;
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ===== hdl/frustum_culling_planes.sv =====
// Frustum culling planes: top level with config registers, front, engine and queues.
// Each camera pose (position, view direction, up vector) yields six planes in the
// order left, right, bottom, top, near, far, popped one per transaction. Each side
// plane with a non-zero edge runs a 32-step square root, a 31-step divider and a
// one-bit-per-cycle normalizing shift of up to 30 steps, and all products go
// through a single shared 33x33 multiplier. The front forms the right axis and can
// hold a further pose while the engine is busy. Extents and distances must be
// written only while no pose is in flight.
module frustum_culling_planes
   import fcp_pkg::*;
#(
   parameter int PoseQueueDepth   = 2,
   parameter int ResultQueueDepth = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        push,
   output logic        full,
   input  logic [47:0] req_pos_x,
   input  logic [47:0] req_pos_y,
   input  logic [47:0] req_pos_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic [31:0] req_up_x,
   input  logic [31:0] req_up_y,
   input  logic [31:0] req_up_z,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_plane_index,
   output logic [31:0] rsp_normal_x,
   output logic [31:0] rsp_normal_y,
   output logic [31:0] rsp_normal_z,
   output logic [47:0] rsp_plane_offset,
   output logic        rsp_degenerate,
   output logic        rsp_last_plane
);
   cfg_type          cfg_ff, cfg_in;
   logic [2:0][47:0] pos;
   logic [2:0][31:0] dir;
   logic [2:0][31:0] up;
   logic             pq_push, pq_full, pq_pop, pq_empty;
   pose_type         pq_wr, pq_rd;
   logic             oq_push, oq_full;
   plane_type        oq_wr, oq_rd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we && (csr_index <= CFG_FAR)) begin
         cfg_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_LEFT]   <= 32'hFFFF_0000;
         cfg_ff[CFG_RIGHT]  <= 32'h0001_0000;
         cfg_ff[CFG_BOTTOM] <= 32'hFFFF_0000;
         cfg_ff[CFG_TOP]    <= 32'h0001_0000;
         cfg_ff[CFG_NEAR]   <= 32'h0001_0000;
         cfg_ff[CFG_FAR]    <= 32'h03E8_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pos = {req_pos_z, req_pos_y, req_pos_x};
   assign dir = {req_dir_z, req_dir_y, req_dir_x};
   assign up  = {req_up_z, req_up_y, req_up_x};

   fcp_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .full   (full),
      .pos    (pos),
      .dir    (dir),
      .up     (up),
      .q_push (pq_push),
      .q_item (pq_wr),
      .q_full (pq_full)
   );

   fcp_queue #(
      .item_type (pose_type),
      .Depth     (PoseQueueDepth)
   ) u_pose_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pq_push),
      .wr_item (pq_wr),
      .full    (pq_full),
      .rd_en   (pq_pop),
      .rd_item (pq_rd),
      .empty   (pq_empty)
   );

   fcp_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (pq_empty),
      .q_item  (pq_rd),
      .q_pop   (pq_pop),
      .o_push  (oq_push),
      .o_item  (oq_wr),
      .o_full  (oq_full)
   );

   fcp_queue #(
      .item_type (plane_type),
      .Depth     (ResultQueueDepth)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (oq_push),
      .wr_item (oq_wr),
      .full    (oq_full),
      .rd_en   (pop),
      .rd_item (oq_rd),
      .empty   (empty)
   );

   assign rsp_plane_index  = oq_rd.plane_index;
   assign rsp_normal_x     = oq_rd.normal[0];
   assign rsp_normal_y     = oq_rd.normal[1];
   assign rsp_normal_z     = oq_rd.normal[2];
   assign rsp_plane_offset = oq_rd.plane_offset;
   assign rsp_degenerate   = oq_rd.degenerate;
   assign rsp_last_plane   = oq_rd.last_plane;

endmodule

// ===== bench/tb_frustum_culling_planes.sv =====
// Testbench for frustum_culling_planes: table and random camera poses checked against a predictor.
`timescale 1ns / 1ps

module tb_frustum_culling_planes;
   import fcp_pkg::*;

   localparam int GAP_MAX = 15;
   localparam int RANDOM_PER_PHASE = 26;
   localparam int NUM_PHASES = 7;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 600;
   localparam logic [31:0] ONE = 32'h4000_0000;
   localparam logic [31:0] NEG_ONE = 32'hC000_0000;
   localparam logic [31:0] S32_TOP = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_BOT = 32'h8000_0000;
   localparam logic [47:0] P48_TOP = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] P48_BOT = 48'h8000_0000_0000;
   localparam logic [2:0] CFG_SPARE_A = 3'd6;
   localparam logic [2:0] CFG_SPARE_B = 3'd7;

   typedef struct packed {
      logic [47:0] px, py, pz;
      logic [31:0] dx, dy, dz, ux, uy, uz;
   } tb_pose_type;

   typedef struct packed {
      logic [2:0]  idx;
      logic [31:0] nx, ny, nz;
      logic [47:0] off;
      logic        deg;
      logic        last;
   } tb_plane_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic push = 1'b0;
   logic full;
   logic [47:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic empty;
   logic pop = 1'b0;
   logic [2:0] rsp_plane_index;
   logic [31:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [47:0] rsp_plane_offset;
   logic rsp_degenerate, rsp_last_plane;

   frustum_culling_planes DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(push), .full(full),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_up_x(req_up_x), .req_up_y(req_up_y), .req_up_z(req_up_z),
      .empty(empty), .pop(pop),
      .rsp_plane_index(rsp_plane_index), .rsp_normal_x(rsp_normal_x),
      .rsp_normal_y(rsp_normal_y), .rsp_normal_z(rsp_normal_z),
      .rsp_plane_offset(rsp_plane_offset), .rsp_degenerate(rsp_degenerate),
      .rsp_last_plane(rsp_last_plane)
   );

   always #6 clock = ~clock;

   longint frustum_cfg[6];
   tb_plane_type planes_due[$];
   int errors = 0;
   bit burst = 1'b0;
   int idle_cycles = 0;

   task automatic queue_plane(input tb_plane_type p);
      planes_due.insert(planes_due.size(), p);
   endtask

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic cross3(input longint a[3], input longint b[3], output longint c[3]);
      c[0] = clip((a[1] * b[2] >>> 30) - (a[2] * b[1] >>> 30), -(64'sd1 <<< 31), 64'sd2147483647);
      c[1] = clip((a[2] * b[0] >>> 30) - (a[0] * b[2] >>> 30), -(64'sd1 <<< 31), 64'sd2147483647);
      c[2] = clip((a[0] * b[1] >>> 30) - (a[1] * b[0] >>> 30), -(64'sd1 <<< 31), 64'sd2147483647);
   endtask

   task automatic make_unit(input longint e[3], output longint u[3], output bit ok);
      longint unsigned m, a, n2, len;
      longint t[3];
      int s;
      m = 0;
      s = 0;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
         a = (e[i] < 0) ? longint'(-e[i]) : longint'(e[i]);
         if (a > m) m = a;
      end
      ok = (m != 0);
      u[0] = 0; u[1] = 0; u[2] = 0;
      if (ok) begin
         if (m >= (64'd1 << 31)) begin
            while ((m >> s) >= (64'd1 << 31)) s++;
            for (int i = 0; i < 3; i++) t[i] = e[i] >>> s;
         end else begin
            while ((m << s) < (64'd1 << 30)) s++;
            for (int i = 0; i < 3; i++) t[i] = e[i] <<< s;
         end
         for (int i = 0; i < 3; i++) n2 += longint'(t[i] * t[i]);
         len = int_sqrt(n2);
         for (int i = 0; i < 3; i++) u[i] = (t[i] <<< 30) / longint'(len);
      end
   endtask

   function automatic longint plane_dist(longint n[3], longint p[3]);
      logic signed [127:0] acc, a, b;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         a = n[i];
         b = p[i];
         acc = acc + a * b;
      end
      acc = -(acc >>> 30);
      if (acc > $signed({80'd0, P48_TOP})) return longint'($signed(P48_TOP));
      if (acc < -$signed({80'd0, P48_TOP}) - 1) return -longint'($signed(P48_TOP)) - 1;
      return longint'(acc);
   endfunction

   function automatic tb_plane_type pack_plane(logic [2:0] idx, longint n[3], longint off,
                                               bit deg);
      tb_plane_type r;
      r.idx = idx;
      r.nx = n[0][31:0];
      r.ny = n[1][31:0];
      r.nz = n[2][31:0];
      r.off = off[47:0];
      r.deg = deg;
      r.last = (idx == PLANE_FAR);
      return r;
   endfunction

   task automatic predict_planes(input tb_pose_type c);
      longint pos[3], dir[3], up[3], rt[3], e[3], u[3], n[3], pt[3];
      longint pmax, pmin;
      bit ok;
      pmax = longint'($signed(P48_TOP));
      pmin = -pmax - 1;
      pos[0] = $signed(c.px); pos[1] = $signed(c.py); pos[2] = $signed(c.pz);
      dir[0] = $signed(c.dx); dir[1] = $signed(c.dy); dir[2] = $signed(c.dz);
      up[0] = $signed(c.ux); up[1] = $signed(c.uy); up[2] = $signed(c.uz);
      cross3(dir, up, rt);
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++)
            e[i] = (((k < 2) ? rt[i] : up[i]) * frustum_cfg[k] >>> 16)
                   + (dir[i] * frustum_cfg[CFG_NEAR] >>> 16);
         make_unit(e, u, ok);
         if (!ok) begin
            n[0] = 0; n[1] = 0; n[2] = 0;
            queue_plane(pack_plane(k[2:0], n, 0, 1'b1));
         end else begin
            case (k[2:0])
               PLANE_LEFT: cross3(u, up, n);
               PLANE_RIGHT: cross3(up, u, n);
               PLANE_BOTTOM: cross3(rt, u, n);
               default: cross3(u, rt, n);
            endcase
            queue_plane(pack_plane(k[2:0], n, plane_dist(n, pos), 1'b0));
         end
      end
      for (int i = 0; i < 3; i++)
         pt[i] = clip(pos[i] + (dir[i] * frustum_cfg[CFG_NEAR] >>> 30), pmin, pmax);
      queue_plane(pack_plane(PLANE_NEAR, dir, plane_dist(dir, pt), 1'b0));
      for (int i = 0; i < 3; i++) begin
         pt[i] = clip(pos[i] + (dir[i] * frustum_cfg[CFG_FAR] >>> 30), pmin, pmax);
         n[i] = clip(-dir[i], -(64'sd1 <<< 31), 64'sd2147483647);
      end
      queue_plane(pack_plane(PLANE_FAR, n, plane_dist(n, pt), 1'b0));
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx < NUM_CFG) frustum_cfg[idx] = longint'($signed(v));
   endtask

   task automatic send_pose(input tb_pose_type c, input bit typed_zero);
      int gap;
      gap = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      {req_pos_x, req_pos_y, req_pos_z} <= {c.px, c.py, c.pz};
      {req_dir_x, req_dir_y, req_dir_z} <= {c.dx, c.dy, c.dz};
      {req_up_x, req_up_y, req_up_z} <= {c.ux, c.uy, c.uz};
      @(posedge clock);
      while (full) @(posedge clock);
      if (typed_zero) begin
         // zero direction and up: every side edge is zero, every normal and offset zero
         for (int k = 0; k < 6; k++)
            queue_plane('{idx: k[2:0], nx: '0, ny: '0, nz: '0, off: '0,
                          deg: (k < 4), last: (k == PLANE_FAR)});
      end else begin
         predict_planes(c);
      end
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   function automatic logic [31:0] wiggle(logic [31:0] base);
      return base + $urandom_range(0, 1 << 20) - (1 << 19);
   endfunction

   function automatic tb_pose_type random_pose();
      tb_pose_type c;
      int ax;
      logic [31:0] sgn;
      if ($urandom_range(0, 3) != 0) begin
         ax = $urandom_range(0, 2);
         sgn = $urandom_range(0, 1) ? ONE : NEG_ONE;
         c.px = {{16{$urandom_range(0, 1) == 1}}, 32'($urandom)};
         c.py = {{16{$urandom_range(0, 1) == 1}}, 32'($urandom)};
         c.pz = {{16{$urandom_range(0, 1) == 1}}, 32'($urandom)};
         {c.dx, c.dy, c.dz} = {wiggle(0), wiggle(0), wiggle(0)};
         {c.ux, c.uy, c.uz} = {wiggle(0), wiggle(0), wiggle(0)};
         case (ax)
            0: begin c.dx = wiggle(sgn); c.uy = wiggle(ONE); end
            1: begin c.dy = wiggle(sgn); c.uz = wiggle(ONE); end
            default: begin c.dz = wiggle(sgn); c.ux = wiggle(NEG_ONE); end
         endcase
      end else begin
         c = {rand48(), rand48(), rand48(), 32'($urandom), 32'($urandom), 32'($urandom),
              32'($urandom), 32'($urandom), 32'($urandom)};
      end
      return c;
   endfunction

   tb_pose_type pose_table[14];
   logic [31:0] phase_cfg[NUM_PHASES][6];

   initial begin
      pose_table[0] = '0;
      pose_table[1] = '{'0, '0, '0, '0, '0, NEG_ONE, '0, ONE, '0};
      pose_table[2] = '{48'h1_0000, 48'h2_0000, 48'h3_0000, ONE, '0, '0, '0, '0, ONE};
      pose_table[3] = '{P48_TOP, P48_TOP, P48_TOP, '0, '0, S32_BOT, '0, ONE, '0};
      pose_table[4] = '{P48_BOT, P48_BOT, P48_BOT, S32_TOP, '0, '0, '0, S32_TOP, '0};
      pose_table[5] = '{P48_TOP, P48_BOT, '0, S32_BOT, S32_BOT, S32_BOT,
                        S32_TOP, S32_TOP, S32_TOP};
      pose_table[6] = '{'0, '0, '0, '0, ONE, '0, '0, ONE, '0};
      pose_table[7] = '{'0, '0, '0, 32'h2000_0000, '0, '0, '0, 32'h1000_0000, '0};
      pose_table[8] = '{48'h1234_5678, '0, '0, S32_TOP, S32_TOP, S32_TOP,
                        S32_BOT, '0, S32_TOP};
      pose_table[9] = '{P48_TOP, P48_BOT, P48_TOP, '0, '0, '0, '0, '0, '0};
      pose_table[10] = '{-48'sh5_0000, 48'h7_0000, -48'sh1, '0, '0, ONE, ONE, '0, '0};
      pose_table[11] = '{'1, '1, '1, '1, '1, '1, 32'h1, 32'h1, 32'h1};
      pose_table[12] = '{'0, '0, '0, ONE, '0, '0, '0, '0, '0};
      pose_table[13] = '{'0, '0, '0, '0, '0, NEG_ONE, '0, NEG_ONE, '0};

      phase_cfg[0] = '{-32'sh1_0000, 32'h1_0000, -32'sh1_0000, 32'h1_0000,
                       32'h1_0000, 32'h3E8_0000};
      phase_cfg[1] = '{'0, '0, '0, '0, '0, 32'h3E8_0000};
      phase_cfg[2] = '{S32_BOT, S32_BOT, S32_BOT, S32_BOT, S32_BOT, S32_BOT};
      phase_cfg[3] = '{S32_TOP, S32_TOP, S32_TOP, S32_TOP, S32_TOP, S32_TOP};
      phase_cfg[4] = '{-32'sh3_0000, 32'h1_0000, -32'sh8000, 32'h2_0000,
                       32'hA_0000, 32'h1_0000};
      phase_cfg[5] = '{-32'sh2_8000, 32'h0_4000, -32'sh1_0000, 32'h3_0000,
                       -32'sh1_0000, -32'sh64_0000};
      for (int i = 0; i < 6; i++) phase_cfg[6][i] = $urandom;

      for (int i = 0; i < 6; i++) frustum_cfg[i] = longint'($signed(phase_cfg[0][i]));
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            push <= 1'b0;
            @(posedge clock);
            while (planes_due.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            for (int r = 0; r < 6; r++) csr_write(r[2:0], phase_cfg[ph][r]);
            csr_write(CFG_SPARE_A, $urandom);
            csr_write(CFG_SPARE_B, $urandom);
            csr_we <= 1'b0;
         end
         burst = (ph % 3 == 2);
         foreach (pose_table[i])
            send_pose(pose_table[i], (pose_table[i][191:0] == '0));
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == RANDOM_PER_PHASE / 2) burst = ~burst;
            send_pose(random_pose(), 1'b0);
         end
      end
      push <= 1'b0;
      @(posedge clock);
      while (planes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   initial begin
      tb_plane_type want;
      int stall;
      @(negedge reset);
      forever begin
         stall = burst ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (planes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none got plane %0d",
                     $time, rsp_plane_index);
         end else begin
            want = planes_due.pop_front();
            check_field("plane_index", 48'(want.idx), 48'(rsp_plane_index));
            check_field("normal_x", 48'(want.nx), 48'(rsp_normal_x));
            check_field("normal_y", 48'(want.ny), 48'(rsp_normal_y));
            check_field("normal_z", 48'(want.nz), 48'(rsp_normal_z));
            check_field("plane_offset", want.off, rsp_plane_offset);
            check_field("degenerate", 48'(want.deg), 48'(rsp_degenerate));
            check_field("last_plane", 48'(want.last), 48'(rsp_last_plane));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
